### rtl/cim_pkg.sv
package cim_pkg;

  // Operation codes in BAM numbering that take part in pair collapsing
  localparam logic [3:0] CODE_INS = 4'd1;
  localparam logic [3:0] CODE_DEL = 4'd2;

  localparam int CODE_W = 4;

  // Most words one operation can produce (advance plus final flush)
  localparam int MAX_PUSH = 3;

  // Output queue: depth must be a power of two
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Register map: index taken from paddr[2]
  localparam logic REG_MISMATCH = 1'b0;

  // Push control from the window logic to the output queue
  typedef struct packed {
    logic [MAX_PUSH-1:0] valid;
    logic [MAX_PUSH-1:0] last;
  } cim_push_t;

endpackage

### rtl/cim_step.sv
module cim_step import cim_pkg::*; #(
  parameter int LENGTH_BITS = 28
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [LENGTH_BITS-1:0] in_length_i,
  input  logic [CODE_W-1:0]      in_code_i,
  input  logic                   in_final_i,
  input  logic [CODE_W-1:0]      mismatch_code_i,
  output logic                   stage_valid_o,
  output cim_push_t              push_o,
  output logic [LENGTH_BITS-1:0] push_length_o [MAX_PUSH],
  output logic [CODE_W-1:0]      push_code_o [MAX_PUSH]
);

  localparam logic [LENGTH_BITS-1:0] LenMax = {LENGTH_BITS{1'b1}};

  function automatic logic [LENGTH_BITS-1:0] sat_add(
    input logic [LENGTH_BITS-1:0] a,
    input logic [LENGTH_BITS-1:0] b
  );
    logic [LENGTH_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LENGTH_BITS] ? LenMax : s[LENGTH_BITS-1:0];
  endfunction

  // Input register
  logic                   in_v_q;
  logic [LENGTH_BITS-1:0] in_len_q;
  logic [CODE_W-1:0]      in_code_q;
  logic                   in_fin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      in_len_q  <= in_length_i;
      in_code_q <= in_code_i;
      in_fin_q  <= in_final_i;
    end
  end

  assign stage_valid_o = in_v_q;

  // Window state
  logic [LENGTH_BITS-1:0] old_len_q, old_len_d, open_len_q, open_len_d;
  logic [CODE_W-1:0]      old_code_q, old_code_d, open_code_q, open_code_d;
  logic                   old_v_q, old_v_d, open_v_q, open_v_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_len_q   <= '0;
      old_code_q  <= '0;
      old_v_q     <= 1'b0;
      open_len_q  <= '0;
      open_code_q <= '0;
      open_v_q    <= 1'b0;
    end else begin
      old_len_q   <= old_len_d;
      old_code_q  <= old_code_d;
      old_v_q     <= old_v_d;
      open_len_q  <= open_len_d;
      open_code_q <= open_code_d;
      open_v_q    <= open_v_d;
    end
  end

  // Pair collapse terms
  logic                   open_longer;
  logic [LENGTH_BITS-1:0] short_len, diff_len, open_sum, old_sum;
  logic [CODE_W-1:0]      rem_code;
  logic                   is_pair;

  assign open_longer = open_len_q > in_len_q;
  assign short_len   = (open_len_q < in_len_q) ? open_len_q : in_len_q;
  assign diff_len    = open_longer ? (open_len_q - in_len_q) : (in_len_q - open_len_q);
  assign rem_code    = open_longer ? open_code_q : in_code_q;
  assign open_sum    = sat_add(open_len_q, in_len_q);
  assign old_sum     = sat_add(old_len_q, short_len);
  assign is_pair     = (open_code_q == CODE_INS && in_code_q == CODE_DEL) ||
                       (open_code_q == CODE_DEL && in_code_q == CODE_INS);

  // Advance the window and build output words
  always_comb begin
    old_len_d   = old_len_q;
    old_code_d  = old_code_q;
    old_v_d     = old_v_q;
    open_len_d  = open_len_q;
    open_code_d = open_code_q;
    open_v_d    = open_v_q;
    push_o      = '0;
    for (int i = 0; i < MAX_PUSH; i++) begin
      push_length_o[i] = old_len_q;
      push_code_o[i]   = old_code_q;
    end

    if (in_v_q) begin
      if (!open_v_q) begin
        open_len_d  = in_len_q;
        open_code_d = in_code_q;
        open_v_d    = 1'b1;
      end else if (open_code_q == in_code_q) begin
        open_len_d = open_sum;
      end else if (is_pair) begin
        if (old_v_q && old_code_q == mismatch_code_i) begin
          old_len_d = old_sum;
          if (diff_len != '0) begin
            open_len_d  = diff_len;
            open_code_d = rem_code;
          end else begin
            // merged entry becomes the open one, older slot empties
            open_len_d  = old_sum;
            open_code_d = old_code_q;
            old_v_d     = 1'b0;
          end
        end else if (diff_len != '0) begin
          push_o.valid[0] = old_v_q;
          old_len_d       = short_len;
          old_code_d      = mismatch_code_i;
          old_v_d         = 1'b1;
          open_len_d      = diff_len;
          open_code_d     = rem_code;
        end else begin
          open_len_d  = short_len;
          open_code_d = mismatch_code_i;
        end
      end else begin
        push_o.valid[0] = old_v_q;
        old_len_d       = open_len_q;
        old_code_d      = open_code_q;
        old_v_d         = 1'b1;
        open_len_d      = in_len_q;
        open_code_d     = in_code_q;
      end

      // Flush on the last operation of a list
      if (in_fin_q) begin
        push_o.valid[1]  = old_v_d;
        push_length_o[1] = old_len_d;
        push_code_o[1]   = old_code_d;
        push_o.valid[2]  = 1'b1;
        push_o.last[2]   = 1'b1;
        push_length_o[2] = open_len_d;
        push_code_o[2]   = open_code_d;
        old_len_d        = '0;
        old_code_d       = '0;
        old_v_d          = 1'b0;
        open_len_d       = '0;
        open_code_d      = '0;
        open_v_d         = 1'b0;
      end
    end
  end

  // Older entry only exists behind an open one
  a_old_needs_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    old_v_q |-> open_v_q)
    else $error("older entry valid without open entry");

  // A final operation leaves the window empty
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && in_fin_q) |=> (!open_v_q && !old_v_q))
    else $error("window not empty after final operation");

  // Only a final operation raises the last flag
  a_last_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.last[2] |-> (in_v_q && in_fin_q))
    else $error("last flag without final operation");

endmodule

### rtl/cim_fifo.sv
module cim_fifo import cim_pkg::*; #(
  parameter int LENGTH_BITS = 28
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cim_push_t              push_i,
  input  logic [LENGTH_BITS-1:0] push_length_i [MAX_PUSH],
  input  logic [CODE_W-1:0]      push_code_i [MAX_PUSH],
  input  logic                   pop_i,
  output logic                   out_valid_o,
  output logic [LENGTH_BITS-1:0] out_length_o,
  output logic [CODE_W-1:0]      out_code_o,
  output logic                   out_last_o,
  output logic [CNT_W-1:0]       count_o
);

  logic [LENGTH_BITS-1:0] len_mem  [FIFO_DEPTH];
  logic [CODE_W-1:0]      code_mem [FIFO_DEPTH];
  logic                   last_mem [FIFO_DEPTH];

  logic [PTR_W-1:0] head_q, tail_q;
  logic [CNT_W-1:0] count_q, count_d, npush;
  logic [PTR_W-1:0] offset [MAX_PUSH];
  logic             pop;

  // Pack valid words without gaps behind the tail
  always_comb begin
    offset[0] = '0;
    for (int i = 1; i < MAX_PUSH; i++) begin
      offset[i] = offset[i-1] + PTR_W'(push_i.valid[i-1]);
    end
    npush = '0;
    for (int i = 0; i < MAX_PUSH; i++) begin
      npush = npush + CNT_W'(push_i.valid[i]);
    end
  end

  assign pop     = pop_i && (count_q != '0);
  assign count_d = count_q + npush - CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_q + PTR_W'(pop);
      tail_q  <= tail_q + npush[PTR_W-1:0];
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_PUSH; i++) begin
      if (push_i.valid[i]) begin
        len_mem[tail_q + offset[i]]  <= push_length_i[i];
        code_mem[tail_q + offset[i]] <= push_code_i[i];
        last_mem[tail_q + offset[i]] <= push_i.last[i];
      end
    end
  end

  assign out_valid_o  = count_q != '0;
  assign out_length_o = len_mem[head_q];
  assign out_code_o   = code_mem[head_q];
  assign out_last_o   = last_mem[head_q];
  assign count_o      = count_q;

  // Pushes never overrun the queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, count_q} + {1'b0, npush}) <= (CNT_W + 1)'(FIFO_DEPTH))
    else $error("output queue overflow");

  // Fill level tracks pushes and pops
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count_q == $past(count_d))
    else $error("output queue count mismatch");

endmodule

### rtl/cigar_indel_merger.sv
// CIGAR operation compactor. Each input word carries one operation (length in
// tdata low bits, code above it, tlast marking the last operation of a list).
// Adjacent equal codes merge with saturating length sums; an insertion next
// to a deletion collapses into the mismatch code held in register 0 (byte
// address 0), keeping the shorter length and leaving any surplus as the
// longer indel. An operation is taken every cycle while s_tready is high:
// it is registered, run through the window logic, and its 0 to 3 result
// words go into an eight-word output queue. s_tready drops while that
// queue lacks room for the words the registered and the incoming operation
// may still produce, so input can stall even while the output side drains.
// The result word flagged with tlast closes each compacted list.
module cigar_indel_merger import cim_pkg::*; #(
  parameter int LENGTH_BITS = 28,
  localparam int DataW = ((LENGTH_BITS + CODE_W + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input operations
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [DataW-1:0]    s_tdata,   // run_length, run_code, zero pad
  input  logic                s_tlast,   // is_final
  // Result operations
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [DataW-1:0]    m_tdata,   // out_length, out_code, zero pad
  output logic                m_tlast,   // out_last
  // Configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Configuration register
  logic [CODE_W-1:0] mismatch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mismatch_q <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_MISMATCH) begin
      mismatch_q <= pwdata[CODE_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MISMATCH) ? {{(32 - CODE_W){1'b0}}, mismatch_q} : '0;

  // Window logic
  logic                   accept, stage_valid;
  cim_push_t              push;
  logic [LENGTH_BITS-1:0] push_length [MAX_PUSH];
  logic [CODE_W-1:0]      push_code [MAX_PUSH];
  logic [CNT_W-1:0]       fifo_count;
  logic [LENGTH_BITS-1:0] out_length;
  logic [CODE_W-1:0]      out_code;
  logic [CNT_W:0]         room_need;

  assign accept = s_tvalid && s_tready;

  cim_step #(.LENGTH_BITS(LENGTH_BITS)) u_step (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (accept),
    .in_length_i    (s_tdata[LENGTH_BITS-1:0]),
    .in_code_i      (s_tdata[LENGTH_BITS+CODE_W-1:LENGTH_BITS]),
    .in_final_i     (s_tlast),
    .mismatch_code_i(mismatch_q),
    .stage_valid_o  (stage_valid),
    .push_o         (push),
    .push_length_o  (push_length),
    .push_code_o    (push_code)
  );

  // Hold input unless the queue can take both operations' worst case
  assign room_need = {1'b0, fifo_count} + (CNT_W + 1)'(MAX_PUSH)
                   + (stage_valid ? (CNT_W + 1)'(MAX_PUSH) : '0);
  assign s_tready  = room_need <= (CNT_W + 1)'(FIFO_DEPTH);

  cim_fifo #(.LENGTH_BITS(LENGTH_BITS)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_length_i(push_length),
    .push_code_i  (push_code),
    .pop_i        (m_tready),
    .out_valid_o  (m_tvalid),
    .out_length_o (out_length),
    .out_code_o   (out_code),
    .out_last_o   (m_tlast),
    .count_o      (fifo_count)
  );

  assign m_tdata = DataW'({out_code, out_length});

endmodule
